// ----- rtl/core/bdtu_pkg.sv -----
`default_nettype none

package bdtu_pkg;

    // Calendar constants
    localparam int unsigned EPOCH_OFS   = 719468;   // days from 0000-03-01 to 1970-01-01
    localparam int unsigned ERA_DAYS    = 146097;   // days in 400 years
    localparam int unsigned LAST_DOE    = 146096;   // last day of an era
    localparam int unsigned YEAR_BASE   = 1900;
    localparam int unsigned MAX_YEAR    = 2147483647;

    // Pipeline payload, one copy per stage
    typedef struct packed {
        logic signed [31:0] mi;
        logic signed [31:0] h;
        logic signed [31:0] md;
        logic signed [31:0] yr;
        logic               dst;
        logic [5:0]         sec;
        logic [5:0]         min;
        logic [4:0]         hour;
        logic [3:0]         month;
        logic signed [25:0] era_y;
        logic signed [33:0] base;
        logic signed [43:0] ema;
        logic signed [43:0] day;
        logic signed [63:0] dprod;
        logic [16:0]        hms;
        logic signed [63:0] t;
        logic               ovf;
        logic signed [26:0] era;
        logic [17:0]        doe;
        logic [2:0]         wday;
        logic [8:0]         yoe2;
        logic [8:0]         doy;
        logic [3:0]         mp;
    } t_pipe;

    // Leap test on a year taken mod 400 (0 and 400 both mean a multiple of 400)
    function automatic logic f_leap(input logic [8:0] v);
        logic r;
        r = (v == 9'd0) || (v == 9'd400) ||
            ((v[1:0] == 2'd0) && (v != 9'd100) && (v != 9'd200) && (v != 9'd300));
        return r;
    endfunction

    // Whole centuries in a year-of-era
    function automatic logic [1:0] f_cent(input logic [8:0] y);
        logic [1:0] c;
        if (y >= 9'd300) begin
            c = 2'd3;
        end else if (y >= 9'd200) begin
            c = 2'd2;
        end else if (y >= 9'd100) begin
            c = 2'd1;
        end else begin
            c = 2'd0;
        end
        return c;
    endfunction

    // Days before the first of a zero-based month
    function automatic logic [8:0] f_dbm(input logic leap, input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        if (leap && (m >= 4'd2)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/broken_down_time_to_unix_seconds.sv -----
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_seconds_in .. i_dst_in
// result    out        o_valid / i_stall  o_unix_seconds .. o_dst_out
//
// One transaction in per cycle while no result is held, one result per transaction.
// The latency is the chain of eight dependent constant dividers (two stages
// each), the day-of-year stage and the output register; the other dividers
// and the multiplies run beside that chain.
// Reset clears the stage valid bits only; payload flows without reset.
// A stalled result freezes the whole pipeline; o_stall is raised while it waits.
module broken_down_time_to_unix_seconds
    import bdtu_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  signed [31:0] i_seconds_in,
    input  wire  signed [31:0] i_minutes_in,
    input  wire  signed [31:0] i_hours_in,
    input  wire  signed [31:0] i_month_day_in,
    input  wire  signed [31:0] i_month_in,
    input  wire  signed [31:0] i_year_in,
    input  wire  signed [7:0]  i_dst_in,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [63:0] o_unix_seconds,
    output logic               o_overflow,
    output logic [5:0]         o_seconds_out,
    output logic [5:0]         o_minutes_out,
    output logic [4:0]         o_hours_out,
    output logic [4:0]         o_month_day_out,
    output logic [3:0]         o_month_out,
    output logic [30:0]        o_year_out,
    output logic [2:0]         o_week_day,
    output logic [8:0]         o_year_day,
    output logic               o_dst_out
);

    localparam int NS = 17;

    logic          en;
    logic [NS:1]   r_v;
    t_pipe         r_c [1:NS];
    t_pipe         n_c [1:NS];
    logic          r_o_v;

    // divider ports
    logic signed [31:0] q_s;      logic [5:0]  rm_s;
    logic signed [31:0] q_mo;     logic [3:0]  rm_mo;
    logic signed [32:0] x_a;      logic signed [32:0] q_a;     logic [5:0]  rm_a;
    logic signed [32:0] x_ym;     logic signed [32:0] q_ym;    logic [8:0]  rm_ym;
    logic signed [32:0] x_th;     logic signed [32:0] q_th;    logic [4:0]  rm_th;
    logic signed [32:0] x_w;      logic signed [32:0] q_w;     logic [17:0] rm_w;
    logic signed [18:0] x_doe;    logic signed [18:0] q_1460;  logic [10:0] rm_1460;
    logic signed [18:0] q_36524;  logic [15:0] rm_36524;
    logic signed [18:0] x_wd;     logic signed [18:0] q_wd;    logic [2:0]  rm_wd;
    logic signed [18:0] x_yn;     logic signed [18:0] q_yn;    logic [8:0]  rm_yn;
    logic signed [11:0] x_mp;     logic signed [11:0] q_mp;    logic [7:0]  rm_mp;
    logic signed [11:0] x_md;     logic signed [11:0] q_md;    logic [2:0]  rm_md;

    // stage helpers
    logic [8:0]         yoe_y;
    logic [17:0]        doe_y;
    logic signed [34:0] w35;
    logic [17:0]        ynum;
    logic [3:0]         mm;
    logic               adj;
    logic [4:0]         cd;
    logic [8:0]         yday;
    logic signed [34:0] cy;
    logic               ovf_all;

    assign en      = !(r_o_v && i_stall);
    assign o_stall = r_o_v && i_stall;

    // Dividers along the pipeline
    bdtu_fdiv #(.N(31), .D(60))     u_div_s   (.i_clk, .i_en(en), .i_x(i_seconds_in),
                                               .o_q(q_s),     .o_r(rm_s));
    bdtu_fdiv #(.N(31), .D(12))     u_div_mo  (.i_clk, .i_en(en), .i_x(i_month_in),
                                               .o_q(q_mo),    .o_r(rm_mo));
    bdtu_fdiv #(.N(32), .D(60))     u_div_mi  (.i_clk, .i_en(en), .i_x(x_a),
                                               .o_q(q_a),     .o_r(rm_a));
    bdtu_fdiv #(.N(32), .D(400))    u_div_yr  (.i_clk, .i_en(en), .i_x(x_ym),
                                               .o_q(q_ym),    .o_r(rm_ym));
    bdtu_fdiv #(.N(32), .D(24))     u_div_hr  (.i_clk, .i_en(en), .i_x(x_th),
                                               .o_q(q_th),    .o_r(rm_th));
    bdtu_fdiv #(.N(32), .D(146097)) u_div_era (.i_clk, .i_en(en), .i_x(x_w),
                                               .o_q(q_w),     .o_r(rm_w));
    bdtu_fdiv #(.N(18), .D(1460))   u_div_4y  (.i_clk, .i_en(en), .i_x(x_doe),
                                               .o_q(q_1460),  .o_r(rm_1460));
    bdtu_fdiv #(.N(18), .D(36524))  u_div_cy  (.i_clk, .i_en(en), .i_x(x_doe),
                                               .o_q(q_36524), .o_r(rm_36524));
    bdtu_fdiv #(.N(18), .D(7))      u_div_wd  (.i_clk, .i_en(en), .i_x(x_wd),
                                               .o_q(q_wd),    .o_r(rm_wd));
    bdtu_fdiv #(.N(18), .D(365))    u_div_yoe (.i_clk, .i_en(en), .i_x(x_yn),
                                               .o_q(q_yn),    .o_r(rm_yn));
    bdtu_fdiv #(.N(11), .D(153))    u_div_mp  (.i_clk, .i_en(en), .i_x(x_mp),
                                               .o_q(q_mp),    .o_r(rm_mp));
    bdtu_fdiv #(.N(11), .D(5))      u_div_md  (.i_clk, .i_en(en), .i_x(x_md),
                                               .o_q(q_md),    .o_r(rm_md));

    // Per-stage datapath
    always_comb begin
        n_c[1]     = '0;
        n_c[1].mi  = i_minutes_in;
        n_c[1].h   = i_hours_in;
        n_c[1].md  = i_month_day_in;
        n_c[1].yr  = i_year_in;
        n_c[1].dst = !i_dst_in[7] && (i_dst_in != 8'sd0);

        n_c[2] = r_c[1];

        // carry leftover seconds into minutes; month carry into year
        x_a  = {q_s[31], q_s} + {r_c[2].mi[31], r_c[2].mi};
        x_ym = {r_c[2].yr[31], r_c[2].yr} + {q_mo[31], q_mo} + 33'(YEAR_BASE - 1);
        n_c[3]       = r_c[2];
        n_c[3].sec   = rm_s;
        n_c[3].month = rm_mo;

        n_c[4] = r_c[3];

        // minutes into hours; day of Jan 1 within its era plus month and day offsets
        x_th  = q_a + {r_c[4].h[31], r_c[4].h};
        yoe_y = rm_ym;
        doe_y = 18'(yoe_y) * 18'd365 + 18'(yoe_y >> 2) - 18'(f_cent(yoe_y)) + 18'd306;
        n_c[5]       = r_c[4];
        n_c[5].min   = rm_a;
        n_c[5].era_y = 26'(q_ym);
        n_c[5].base  = 34'(doe_y)
                     + 34'(f_dbm(f_leap(yoe_y + 9'd1), r_c[4].month))
                     + {{2{r_c[4].md[31]}}, r_c[4].md} - 34'd1;

        n_c[6]     = r_c[5];
        n_c[6].ema = $signed(44'(r_c[5].era_y)) * 44'sd146097;

        // hours into days; split the day count by era
        w35  = {r_c[6].base[33], r_c[6].base} + {{2{q_th[32]}}, q_th};
        x_w  = w35[32:0];
        n_c[7]      = r_c[6];
        n_c[7].hour = rm_th;
        n_c[7].day  = r_c[6].ema + {{9{w35[34]}}, w35} - 44'(EPOCH_OFS);

        n_c[8]       = r_c[7];
        n_c[8].dprod = $signed(r_c[7].day) * 64'sd86400;
        n_c[8].hms   = 17'(r_c[7].hour) * 17'd3600 + 17'(r_c[7].min) * 17'd60
                     + 17'(r_c[7].sec);

        // timestamp; rebuild the date from day-of-era
        x_doe = {1'b0, rm_w};
        x_wd  = {1'b0, rm_w + 18'd3};
        n_c[9]     = r_c[8];
        n_c[9].t   = r_c[8].dprod + 64'(r_c[8].hms);
        n_c[9].ovf = r_c[8].day[43];
        n_c[9].era = 27'(r_c[8].era_y) + 27'(q_w);
        n_c[9].doe = rm_w;

        n_c[10] = r_c[9];

        ynum = r_c[10].doe - 18'(q_1460) + 18'(q_36524)
             - 18'(r_c[10].doe == 18'(LAST_DOE));
        x_yn = {1'b0, ynum};
        n_c[11]      = r_c[10];
        n_c[11].wday = rm_wd;

        n_c[12] = r_c[11];

        n_c[13]      = r_c[12];
        n_c[13].yoe2 = 9'(q_yn);
        n_c[13].doy  = 9'(r_c[12].doe - (18'(q_yn[8:0]) * 18'd365 + 18'(q_yn[8:2])
                     - 18'(f_cent(q_yn[8:0]))));

        // month from day-of-year (March based)
        x_mp = {1'b0, 11'(r_c[13].doy) * 11'd5 + 11'd2};
        n_c[14] = r_c[13];
        n_c[15] = r_c[14];

        x_md = {1'b0, 11'(q_mp[3:0]) * 11'd153 + 11'd2};
        n_c[16]    = r_c[15];
        n_c[16].mp = q_mp[3:0];

        n_c[17] = r_c[16];

        // final date fields and range check
        mm   = (r_c[17].mp < 4'd10) ? (r_c[17].mp + 4'd3) : (r_c[17].mp - 4'd9);
        adj  = (mm <= 4'd2);
        cd   = 5'(r_c[17].doy - q_md[8:0] + 9'd1);
        yday = f_dbm(f_leap(r_c[17].yoe2 + 9'(adj)), mm - 4'd1)
             + r_c[17].doy - q_md[8:0];
        cy   = $signed(35'(r_c[17].era)) * 35'sd400 + $signed({26'd0, r_c[17].yoe2})
             + $signed({34'd0, adj});
        ovf_all = r_c[17].ovf || (cy > 35'sd2147483647);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r_v   <= {r_v[NS-1:1], i_valid};
            r_o_v <= r_v[NS];
        end
    end

    // Payload stages and output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c <= n_c;
            if (ovf_all) begin
                o_unix_seconds  <= '1;
                o_overflow      <= 1'b1;
                o_seconds_out   <= '0;
                o_minutes_out   <= '0;
                o_hours_out     <= '0;
                o_month_day_out <= '0;
                o_month_out     <= '0;
                o_year_out      <= '0;
                o_week_day      <= '0;
                o_year_day      <= '0;
                o_dst_out       <= 1'b0;
            end else begin
                o_unix_seconds  <= r_c[17].t;
                o_overflow      <= 1'b0;
                o_seconds_out   <= r_c[17].sec;
                o_minutes_out   <= r_c[17].min;
                o_hours_out     <= r_c[17].hour;
                o_month_day_out <= cd;
                o_month_out     <= mm - 4'd1;
                o_year_out      <= 31'(cy - 35'(YEAR_BASE));
                o_week_day      <= r_c[17].wday;
                o_year_day      <= yday;
                o_dst_out       <= r_c[17].dst;
            end
        end
    end

    assign o_valid = r_o_v;

endmodule

`default_nettype wire

// ----- rtl/core/bdtu_fdiv.sv -----
`default_nettype none

// Floor division and non-negative remainder of a signed value by a constant.
// Reciprocal multiply, then product back-off; two register stages.
module bdtu_fdiv #(
    parameter int N = 32,   // magnitude bits of the dividend
    parameter int D = 60    // divisor, not a power of two, below 2**N
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire  signed [N:0]        i_x,
    output logic signed [N:0]        o_q,
    output logic [$clog2(D)-1:0]     o_r
);

    localparam int L = $clog2(D);
    localparam int S = N + L;
    localparam logic [N:0] M = (N+1)'(((64'd1 << S) / 64'(D)) + 64'd1);

    logic              r_neg;
    logic [N-1:0]      r_n;
    logic [2*N:0]      r_p;
    logic [N-1:0]      n_n;
    logic [2*N:0]      n_p;
    logic [N-1:0]      q_u;
    logic [N-1:0]      qd;
    logic [L-1:0]      r_u;
    logic signed [N:0] r_q;
    logic [L-1:0]      r_r;

    // Fold negatives by ones' complement so floor becomes a plain quotient
    always_comb begin
        n_n = i_x[N] ? ~i_x[N-1:0] : i_x[N-1:0];
        n_p = (2*N+1)'(n_n) * (2*N+1)'(M);
    end

    // Quotient from the high product bits, remainder by back-multiply
    always_comb begin
        q_u = N'(r_p >> S);
        qd  = N'(q_u * N'(D));
        r_u = L'(r_n - qd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_x[N];
            r_n   <= n_n;
            r_p   <= n_p;
            r_q   <= r_neg ? ~{1'b0, q_u} : {1'b0, q_u};
            r_r   <= r_neg ? (L'(D - 1) - r_u) : r_u;
        end
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

`default_nettype wire

// ----- rtl/core/bdtu_chk.sv -----
`default_nettype none

// Port-level checks on the converter
module bdtu_chk (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               o_stall,
    input wire               o_valid,
    input wire               i_stall,
    input wire signed [63:0] o_unix_seconds,
    input wire               o_overflow,
    input wire [5:0]         o_seconds_out,
    input wire [5:0]         o_minutes_out,
    input wire [4:0]         o_hours_out,
    input wire [4:0]         o_month_day_out,
    input wire [3:0]         o_month_out,
    input wire [30:0]        o_year_out,
    input wire [2:0]         o_week_day,
    input wire [8:0]         o_year_day,
    input wire               o_dst_out
);

    // overflow result carries all ones and nothing else
    a_ovf_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> (o_unix_seconds == -64'sd1) && (o_year_out == 31'd0) &&
        (o_month_day_out == 5'd0) && (o_year_day == 9'd0) && !o_dst_out)
        else $error("overflow result not cleared");

    // normal result fields in range
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_overflow |-> !o_unix_seconds[63] && (o_seconds_out < 6'd60) &&
        (o_minutes_out < 6'd60) && (o_hours_out < 5'd24) && (o_month_out < 4'd12) &&
        (o_week_day < 3'd7) && (o_month_day_out != 5'd0) && (o_year_day < 9'd366))
        else $error("result field out of range");

    // input side only backs up behind a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // held transaction keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_unix_seconds) && $stable(o_year_out))
        else $error("stalled result changed");

endmodule

bind broken_down_time_to_unix_seconds bdtu_chk u_bdtu_chk (.*);

`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top;
    import bdtu_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;

    // One broken-down time as it enters the block
    typedef struct packed {
        logic signed [31:0] sec;
        logic signed [31:0] min;
        logic signed [31:0] hour;
        logic signed [31:0] mday;
        logic signed [31:0] mon;
        logic signed [31:0] year;
        logic signed [7:0]  dst;
    } civil_t;

    // One conversion result
    typedef struct packed {
        logic signed [63:0] unix;
        logic               ovf;
        logic [5:0]         sec;
        logic [5:0]         min;
        logic [4:0]         hour;
        logic [4:0]         mday;
        logic [3:0]         mon;
        logic [30:0]        year;
        logic [2:0]         wday;
        logic [8:0]         yday;
        logic               dst;
    } stamp_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_seconds_in;
    logic signed [31:0] i_minutes_in;
    logic signed [31:0] i_hours_in;
    logic signed [31:0] i_month_day_in;
    logic signed [31:0] i_month_in;
    logic signed [31:0] i_year_in;
    logic signed [7:0]  i_dst_in;
    logic               o_valid;
    logic               i_stall;
    logic signed [63:0] o_unix_seconds;
    logic               o_overflow;
    logic [5:0]         o_seconds_out;
    logic [5:0]         o_minutes_out;
    logic [4:0]         o_hours_out;
    logic [4:0]         o_month_day_out;
    logic [3:0]         o_month_out;
    logic [30:0]        o_year_out;
    logic [2:0]         o_week_day;
    logic [8:0]         o_year_day;
    logic               o_dst_out;

    broken_down_time_to_unix_seconds i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_seconds_in    (i_seconds_in),
        .i_minutes_in    (i_minutes_in),
        .i_hours_in      (i_hours_in),
        .i_month_day_in  (i_month_day_in),
        .i_month_in      (i_month_in),
        .i_year_in       (i_year_in),
        .i_dst_in        (i_dst_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_unix_seconds  (o_unix_seconds),
        .o_overflow      (o_overflow),
        .o_seconds_out   (o_seconds_out),
        .o_minutes_out   (o_minutes_out),
        .o_hours_out     (o_hours_out),
        .o_month_day_out (o_month_day_out),
        .o_month_out     (o_month_out),
        .o_year_out      (o_year_out),
        .o_week_day      (o_week_day),
        .o_year_day      (o_year_day),
        .o_dst_out       (o_dst_out)
    );

    stamp_t expected_stamps[$];
    int     mismatches;
    int     stamps_checked;
    int     overflow_seen;
    int     items_sent;
    int     sender_idle_pct;
    int     stall_pct;
    int     hold_left;
    int     quiet_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint floor_mod(longint a, longint b);
        longint r;
        r = a % b;
        if (r < 0) r = r + b;
        return r;
    endfunction

    function automatic bit is_leap(longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint month_offset(bit leap, longint m);
        longint tbl[12];
        tbl = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        return tbl[m] + ((leap && m >= 2) ? 1 : 0);
    endfunction

    // Days from the epoch to January 1 of full year y
    function automatic longint jan1_days(longint y);
        longint ym, era, yoe, doe;
        ym  = y - 1;
        era = floor_div(ym, 400);
        yoe = ym - era * 400;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + 306;
        return era * 146097 + doe - 719468;
    endfunction

    // Expected conversion of one broken-down time
    function automatic stamp_t civil_to_unix(civil_t c);
        stamp_t r;
        longint total, tmin, tsec, thour, tmn, tday, thr, day, mon, yr, t;
        longint z, era, doe, yoe, doy, mp, cm, cd, cy, yday;
        bit ovf;
        total = longint'(c.sec) + longint'(c.min) * 60 + longint'(c.hour) * 3600;
        tmin  = floor_div(total, 60);
        tsec  = total - tmin * 60;
        thour = floor_div(tmin, 60);
        tmn   = tmin - thour * 60;
        tday  = floor_div(thour, 24);
        thr   = thour - tday * 24;
        day   = longint'(c.mday) - 1 + tday;
        mon   = floor_mod(longint'(c.mon), 12);
        yr    = longint'(c.year) + floor_div(longint'(c.mon), 12) + 1900;
        day   = day + month_offset(is_leap(yr), mon) + jan1_days(yr);
        t     = day * 86400 + thr * 3600 + tmn * 60 + tsec;
        r     = '0;
        ovf   = (t < 0);
        cy = 0; cm = 1; cd = 1;
        if (!ovf) begin
            // Rebuild the civil date from the day count
            z   = day + 719468;
            era = floor_div(z, 146097);
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            cm  = (mp < 10) ? mp + 3 : mp - 9;
            cd  = doy - (153 * mp + 2) / 5 + 1;
            cy  = yoe + era * 400 + ((cm <= 2) ? 1 : 0);
            if (cy > 64'sd2147483647 || cy < -64'sd2147483648) ovf = 1'b1;
        end
        if (ovf) begin
            r.unix = -64'sd1;
            r.ovf  = 1'b1;
            return r;
        end
        yday   = month_offset(is_leap(cy), cm - 1) + cd - 1;
        r.unix = t;
        r.sec  = tsec[5:0];
        r.min  = tmn[5:0];
        r.hour = thr[4:0];
        r.mday = cd[4:0];
        r.mon  = 4'(cm - 1);
        r.year = 31'(cy - 1900);
        r.wday = 3'(floor_mod(day + 4, 7));
        r.yday = yday[8:0];
        r.dst  = (c.dst > 0);
        return r;
    endfunction

    // Offer one transaction, wait until the block takes it, then at times drop valid for a random gap
    task automatic send_civil(civil_t c);
        int gap;
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_seconds_in   <= c.sec;
        i_minutes_in   <= c.min;
        i_hours_in     <= c.hour;
        i_month_day_in <= c.mday;
        i_month_in     <= c.mon;
        i_year_in      <= c.year;
        i_dst_in       <= c.dst;
        do @(posedge i_clk); while (o_stall);
        expected_stamps.push_back(civil_to_unix(c));
        items_sent++;
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    function automatic civil_t make_civil(int s, int mi, int h, int md, int mo, int y, int d);
        civil_t c;
        c.sec = s; c.min = mi; c.hour = h; c.mday = md; c.mon = mo; c.year = y;
        c.dst = d[7:0];
        return c;
    endfunction

    // Mostly plausible dates with small excursions, some large offsets or years near the top, some full-range noise
    function automatic civil_t random_civil();
        civil_t c;
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) begin
            c.sec  = $urandom_range(0, 70) - 5;
            c.min  = $urandom_range(0, 70) - 5;
            c.hour = $urandom_range(0, 30) - 3;
            c.mday = $urandom_range(0, 34) - 1;
            c.mon  = $urandom_range(0, 15) - 2;
            c.year = $urandom_range(60, 1200);
        end else if (sel < 8) begin
            c.sec  = $urandom_range(0, 200000) - 100000;
            c.min  = $urandom_range(0, 20000) - 10000;
            c.hour = $urandom_range(0, 2000) - 1000;
            c.mday = $urandom_range(0, 4000) - 2000;
            c.mon  = $urandom_range(0, 400) - 200;
            c.year = (sel == 6) ? $urandom_range(0, 600000) : 32'sd2147481700 + $urandom_range(0, 60);
        end else begin
            c.sec  = $urandom;
            c.min  = $urandom;
            c.hour = $urandom;
            c.mday = $urandom;
            c.mon  = $urandom;
            c.year = $urandom;
        end
        c.dst = $urandom;
        return c;
    endfunction

    // Edges of the fields, leap rules, overflow and DST folding
    task automatic test_directed();
        sender_idle_pct = 0;
        stall_pct       = 0;
        send_civil(make_civil(0, 0, 0, 1, 0, 70, 0));
        send_civil(make_civil(59, 59, 23, 31, 11, 69, 1));
        send_civil(make_civil(0, 0, 0, 29, 1, 100, -1));
        send_civil(make_civil(0, 0, 0, 29, 1, 0, 127));
        send_civil(make_civil(0, 0, 0, 31, 11, 100, -128));
        send_civil(make_civil(0, 0, 0, 29, 1, 200, 5));
        send_civil(make_civil(-1, 0, 0, 1, 0, 71, 0));
        send_civil(make_civil(60, 60, 24, 0, 12, 80, 1));
        send_civil(make_civil(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0, 70, 0));
        send_civil(make_civil(32'h80000000, 32'h80000000, 32'h80000000, 1, 0, 300, 0));
        send_civil(make_civil(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 100, 1));
        send_civil(make_civil(0, 0, 0, 32'h80000000, 32'h80000000, 100, 1));
        send_civil(make_civil(0, 0, 0, 1, 0, 32'h7fffffff, 1));
        send_civil(make_civil(0, 0, 0, 1, 0, 32'h80000000, 1));
        send_civil(make_civil(59, 59, 23, 31, 11, 2147481747, 1));
        send_civil(make_civil(0, 0, 0, 1, 0, 2147481748, 1));
        send_civil(make_civil(0, 0, 0, 1, -1, 70, 0));
        send_civil(make_civil(-86400, 0, 0, 1, 0, 70, 0));
        send_civil(make_civil(0, 0, 0, 0, 0, 70, 1));
        send_civil(make_civil(-1, 0, 0, 1, 0, 70, 1));
        go_idle();
    endtask

    task automatic test_random(int n, int idle_pct, int stall_rate);
        sender_idle_pct = idle_pct;
        stall_pct       = stall_rate;
        repeat (n) send_civil(random_civil());
        go_idle();
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_left       = HOLD_CYCLES;
        repeat (60) send_civil(random_civil());
        go_idle();
    endtask

    // Receiver stall
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        stamp_t got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_unix_seconds, o_overflow, o_seconds_out, o_minutes_out, o_hours_out,
                   o_month_day_out, o_month_out, o_year_out, o_week_day, o_year_day,
                   o_dst_out};
            if (expected_stamps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_stamps.pop_front();
                stamps_checked++;
                if (want.ovf) overflow_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result %0d: expected %p, got %p",
                                                   stamps_checked, want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expected_stamps.size());
            $display("broken_down_time_to_unix_seconds: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        mismatches      = 0;
        stamps_checked  = 0;
        overflow_seen   = 0;
        items_sent      = 0;
        quiet_cycles    = 0;
        hold_left       = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_seconds_in    = '0;
        i_minutes_in    = '0;
        i_hours_in      = '0;
        i_month_day_in  = '0;
        i_month_in      = '0;
        i_year_in       = '0;
        i_dst_in        = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(250, 0, 0);
        test_random(250, 72, 0);
        test_random(250, 0, 72);
        test_random(250, 24, 24);
        test_backpressure();
        test_random(100, 50, 50);

        wait (expected_stamps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d conversions, checked %0d results (%0d overflowed)",
                 items_sent, stamps_checked, overflow_seen);
        $display("phases: directed edges, free flow, sender gaps, receiver stalls, long hold");
        if (mismatches == 0 && expected_stamps.size() == 0) begin
            $display("broken_down_time_to_unix_seconds: match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("broken_down_time_to_unix_seconds: mismatch");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/bdtu_pkg.sv
rtl/core/bdtu_fdiv.sv
rtl/core/broken_down_time_to_unix_seconds.sv
rtl/core/bdtu_chk.sv
verif/tb_top.sv
